FILE: hw/rtl/rvec_pkg.sv
// shared types and codes for the register vm execute core
// no dependencies

package rvec_pkg;

  // default sizes
  localparam int unsigned RegCountDef    = 16;
  localparam int unsigned RetDepthDef    = 64;
  localparam int unsigned DataDepthDef   = 256;

  // operation codes
  typedef enum logic [4:0] {
    OP_MOVRI = 5'd0,  OP_MOVRR = 5'd1,  OP_ADDR  = 5'd2,  OP_ADDI  = 5'd3,
    OP_SUBR  = 5'd4,  OP_SUBI  = 5'd5,  OP_MULR  = 5'd6,  OP_MULI  = 5'd7,
    OP_DIVR  = 5'd8,  OP_DIVI  = 5'd9,  OP_CALL  = 5'd10, OP_RET   = 5'd11,
    OP_PRINT = 5'd12, OP_BLE   = 5'd13, OP_BGE   = 5'd14, OP_CMP   = 5'd15,
    OP_JMP   = 5'd16, OP_JE    = 5'd17, OP_JNE   = 5'd18, OP_JL    = 5'd19,
    OP_JLE   = 5'd20, OP_JG    = 5'd21, OP_JGE   = 5'd22, OP_PUSH  = 5'd23,
    OP_POP   = 5'd24
  } op_e;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RET_EMPTY = 3'd1,
    ERR_DATA_UNDR = 3'd2,
    ERR_UNKNOWN   = 3'd3,
    ERR_RET_FULL  = 3'd4,
    ERR_DATA_FULL = 3'd5
  } err_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MULDIV, ST_FIN
  } state_e;

  // input item
  typedef struct packed {
    logic [4:0]         operation;
    logic [15:0]        instruction_address;
    logic [3:0]         first_register;
    logic [3:0]         second_register;
    logic signed [63:0] immediate_value;
    logic [15:0]        jump_target;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [16:0]        next_address;
    logic               print_valid;
    logic signed [63:0] print_value;
    logic [2:0]         error_code;
    logic               done_res;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic start_md;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic md_need;
    logic md_busy;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/rvec_muldiv.sv
// shared iterative 64-bit multiplier and unsigned-magnitude divider
// no package dependency, clock and reset only

module rvec_muldiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        div_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        busy_o,
  output logic [63:0] res_o
);

  logic        busy_q, busy_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        div_q, neg_q;
  logic [63:0] acc_q, opa_q, opb_q;
  logic [64:0] shifted;
  logic        fits;

  // one divide bit per step
  assign shifted = {acc_q, opa_q[63]};
  assign fits    = shifted >= {1'b0, opb_q};

  // control counter
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd63) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= div_i;
      neg_q <= a_i[63] ^ b_i[63];
      acc_q <= '0;
      if (div_i) begin
        opa_q <= a_i[63] ? 64'd0 - a_i : a_i;
        opb_q <= b_i[63] ? 64'd0 - b_i : b_i;
      end else begin
        opa_q <= a_i;
        opb_q <= b_i;
      end
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= fits ? 64'(shifted - {1'b0, opb_q}) : shifted[63:0];
        opa_q <= {opa_q[62:0], fits};
      end else begin
        if (opb_q[0]) acc_q <= acc_q + opa_q;
        opa_q <= {opa_q[62:0], 1'b0};
        opb_q <= {1'b0, opb_q[63:1]};
      end
    end
  end

  assign busy_o = busy_q;
  assign res_o  = div_q ? (neg_q ? 64'd0 - opa_q : opa_q) : acc_q;

endmodule

FILE: hw/rtl/rvec_dpath.sv
// datapath: register file, compare value, both stacks, result register
// depends on rvec_pkg and rvec_muldiv

module rvec_dpath
  import rvec_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT     = RegCountDef,
  parameter int unsigned RETURN_STACK_DEPTH = RetDepthDef,
  parameter int unsigned DATA_STACK_DEPTH   = DataDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  input  in_item_t   in_data_i,
  input  logic       cfg_we_i,
  input  logic [15:0] cfg_data_i,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  localparam int unsigned RIW  = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
  localparam int unsigned RSAW = (RETURN_STACK_DEPTH > 1) ? $clog2(RETURN_STACK_DEPTH) : 1;
  localparam int unsigned RSDW = $clog2(RETURN_STACK_DEPTH + 1);
  localparam int unsigned DSAW = (DATA_STACK_DEPTH > 1) ? $clog2(DATA_STACK_DEPTH) : 1;
  localparam int unsigned DSDW = $clog2(DATA_STACK_DEPTH + 1);

  // register index wrap into the register count
  function automatic logic [7:0] reg_wrap(input logic [3:0] f);
    logic [7:0] v;
    v = {4'b0, f};
    for (int i = 0; i < 8; i++) begin
      if (v >= 8'(REGISTER_COUNT)) v = v - 8'(REGISTER_COUNT);
    end
    return v;
  endfunction

  in_item_t          inst_q;
  logic [15:0]       prog_len_q;
  logic [63:0]       rf_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld_q;
  logic [63:0]       rd_a_q, rd_b_q;
  logic              vld_a_q, vld_b_q;
  logic [16:0]       ret_mem [RETURN_STACK_DEPTH];
  logic [63:0]       dat_mem [DATA_STACK_DEPTH];
  logic [16:0]       ret_top_q;
  logic [63:0]       dat_top_q;
  logic [RSDW-1:0]   ret_depth_q;
  logic [DSDW-1:0]   dat_depth_q;
  logic [63:0]       cmp_q;
  logic              stopped_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [7:0]        ra_w, rb_w;
  logic [RIW-1:0]    ra, rb;
  logic [RSDW-1:0]   ret_dm1;
  logic [DSDW-1:0]   dat_dm1;
  logic [63:0]       a, b, src;
  op_e               op;
  logic [63:0]       md_res;
  logic              md_busy;

  // decoded register indexes
  assign ra_w = reg_wrap(inst_q.first_register);
  assign rb_w = reg_wrap(inst_q.second_register);
  assign ra   = ra_w[RIW-1:0];
  assign rb   = rb_w[RIW-1:0];
  assign op   = op_e'(inst_q.operation);
  assign ret_dm1 = ret_depth_q - RSDW'(1);
  assign dat_dm1 = dat_depth_q - DSDW'(1);

  // operands, never-written registers read as zero
  assign a   = vld_a_q ? rd_a_q : 64'd0;
  assign b   = vld_b_q ? rd_b_q : 64'd0;
  assign src = (op == OP_MOVRR || op == OP_ADDR || op == OP_SUBR ||
                op == OP_MULR || op == OP_DIVR) ? b : 64'(inst_q.immediate_value);

  // execute decision
  logic        wr_en, cmp_we, ret_push, ret_pop, dat_push, dat_pop, take, pvalid;
  logic [63:0] wr_data;
  logic [16:0] nxt;
  err_e        err;
  out_item_t   res;

  always_comb begin
    wr_en    = 1'b0;
    wr_data  = a;
    cmp_we   = 1'b0;
    ret_push = 1'b0;
    ret_pop  = 1'b0;
    dat_push = 1'b0;
    dat_pop  = 1'b0;
    take     = 1'b0;
    pvalid   = 1'b0;
    err      = ERR_NONE;
    nxt      = {1'b0, inst_q.instruction_address} + 17'd1;
    case (op)
      OP_MOVRI, OP_MOVRR: begin
        wr_en = 1'b1; wr_data = src;
      end
      OP_ADDR, OP_ADDI: begin
        wr_en = 1'b1; wr_data = a + src;
      end
      OP_SUBR, OP_SUBI: begin
        wr_en = 1'b1; wr_data = a - src;
      end
      OP_MULR, OP_MULI: begin
        wr_en = 1'b1; wr_data = md_res;
      end
      OP_DIVR, OP_DIVI: begin
        // divide by zero keeps the register, by minus one negates
        if (src == 64'd0) wr_en = 1'b0;
        else if (src == '1) begin
          wr_en = 1'b1; wr_data = 64'd0 - a;
        end else begin
          wr_en = 1'b1; wr_data = md_res;
        end
      end
      OP_CALL: begin
        if (ret_depth_q == RSDW'(RETURN_STACK_DEPTH)) err = ERR_RET_FULL;
        else begin
          ret_push = 1'b1; nxt = {1'b0, inst_q.jump_target};
        end
      end
      OP_RET: begin
        if (ret_depth_q == '0) err = ERR_RET_EMPTY;
        else begin
          ret_pop = 1'b1; nxt = ret_top_q;
        end
      end
      OP_PRINT: pvalid = 1'b1;
      OP_BLE:   take = a[63] || a == 64'd0;
      OP_BGE:   take = !a[63];
      OP_CMP:   cmp_we = 1'b1;
      OP_JMP:   take = 1'b1;
      OP_JE:    take = cmp_q == 64'd0;
      OP_JNE:   take = cmp_q != 64'd0;
      OP_JL:    take = cmp_q[63];
      OP_JLE:   take = cmp_q[63] || cmp_q == 64'd0;
      OP_JG:    take = !cmp_q[63] && cmp_q != 64'd0;
      OP_JGE:   take = !cmp_q[63];
      OP_PUSH: begin
        if (dat_depth_q == DSDW'(DATA_STACK_DEPTH)) err = ERR_DATA_FULL;
        else dat_push = 1'b1;
      end
      OP_POP: begin
        if (dat_depth_q == '0) err = ERR_DATA_UNDR;
        else begin
          dat_pop = 1'b1; wr_en = 1'b1; wr_data = dat_top_q;
        end
      end
      default: err = ERR_UNKNOWN;
    endcase
    if (take) nxt = {1'b0, inst_q.jump_target};

    // errors and a stopped block write no register, stack or compare value
    if (stopped_q || err != ERR_NONE) begin
      wr_en = 1'b0; cmp_we = 1'b0; ret_push = 1'b0; ret_pop = 1'b0;
      dat_push = 1'b0; dat_pop = 1'b0;
    end

    if (stopped_q || err != ERR_NONE) begin
      res.next_address = {1'b0, inst_q.instruction_address};
      res.print_valid  = 1'b0;
      res.print_value  = '0;
      res.error_code   = stopped_q ? ERR_NONE : err;
      res.done_res     = 1'b1;
    end else begin
      res.next_address = nxt;
      res.print_valid  = pvalid;
      res.print_value  = pvalid ? a : 64'd0;
      res.error_code   = ERR_NONE;
      res.done_res     = nxt > {1'b0, prog_len_q};
    end
  end

  // instruction and config registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) inst_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) prog_len_q <= '0;
    else if (cfg_we_i) prog_len_q <= cfg_data_i;
  end

  // register file, registered reads
  always_ff @(posedge clk_i) begin
    rd_a_q  <= rf_q[ra];
    rd_b_q  <= rf_q[rb];
    vld_a_q <= rf_vld_q[ra];
    vld_b_q <= rf_vld_q[rb];
    if (cmd_i.commit && wr_en) rf_q[ra] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rf_vld_q <= '0;
    else if (cmd_i.commit && wr_en) rf_vld_q[ra] <= 1'b1;
  end

  // stack memories, top entry read each cycle
  always_ff @(posedge clk_i) begin
    ret_top_q <= ret_mem[ret_dm1[RSAW-1:0]];
    dat_top_q <= dat_mem[dat_dm1[DSAW-1:0]];
    if (cmd_i.commit && ret_push)
      ret_mem[ret_depth_q[RSAW-1:0]] <= {1'b0, inst_q.instruction_address} + 17'd1;
    if (cmd_i.commit && dat_push) dat_mem[dat_depth_q[DSAW-1:0]] <= a;
  end

  // control state: depths, compare value, stop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_depth_q <= '0;
      dat_depth_q <= '0;
      cmp_q       <= '0;
      stopped_q   <= 1'b0;
    end else if (cmd_i.commit) begin
      if (ret_push) ret_depth_q <= ret_depth_q + RSDW'(1);
      if (ret_pop)  ret_depth_q <= ret_dm1;
      if (dat_push) dat_depth_q <= dat_depth_q + DSDW'(1);
      if (dat_pop)  dat_depth_q <= dat_dm1;
      if (cmp_we)   cmp_q <= a - b;
      if (err != ERR_NONE) stopped_q <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) out_q <= res;
  end

  // shared multiply and divide unit
  rvec_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start_md),
    .div_i   (op == OP_DIVR || op == OP_DIVI),
    .a_i     (a),
    .b_i     (src),
    .busy_o  (md_busy),
    .res_o   (md_res)
  );

  assign status_o.md_need  = !stopped_q && (op == OP_MULR || op == OP_MULI ||
                             ((op == OP_DIVR || op == OP_DIVI) &&
                              src != 64'd0 && src != '1));
  assign status_o.md_busy  = md_busy;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(stopped_q)) else $error("stop flag cleared without reset");
  a_ret_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ret_depth_q <= RSDW'(RETURN_STACK_DEPTH)) else $error("return stack overrun");
  a_dat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dat_depth_q <= DSDW'(DATA_STACK_DEPTH)) else $error("data stack overrun");
  a_commit_idle_md: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !md_busy) else $error("commit while multiply/divide busy");

endmodule

FILE: hw/rtl/rvec_ctrl.sv
// controller state machine sequencing one item at a time
// depends on rvec_pkg

module rvec_ctrl
  import rvec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    cmd_o.capture  = 1'b0;
    cmd_o.start_md = 1'b0;
    cmd_o.commit   = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (status_i.md_need) begin
          cmd_o.start_md = 1'b1;
          state_d = ST_MULDIV;
        end else state_d = ST_FIN;
      end
      ST_MULDIV: if (!status_i.md_busy) state_d = ST_FIN;
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/register_vm_execute_core_unit.sv
// Execute core of a register vm: one decoded instruction per item.
// Sequence per item: idle (accept), read, execute, a multiply/divide state for
// the shared radix-2 iterative unit when needed, finish (commit, waits for the
// output to be free). A new item is accepted only after the last is committed.
// Reset: asynchronous active low; registers, depths and compare value clear.
// depends on rvec_pkg, rvec_ctrl, rvec_dpath

module register_vm_execute_core_unit
  import rvec_pkg::*;
#(
  parameter int unsigned REGISTER_COUNT     = RegCountDef,
  parameter int unsigned RETURN_STACK_DEPTH = RetDepthDef,
  parameter int unsigned DATA_STACK_DEPTH   = DataDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // config is always taken
  assign cfg_ready_o = 1'b1;

  rvec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rvec_dpath #(
    .REGISTER_COUNT     (REGISTER_COUNT),
    .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
    .DATA_STACK_DEPTH   (DATA_STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: bench/register_vm_execute_core_unit_checker.sv
// checker for the register vm execute core: watches the item, result and config channels
// predicts each result from its own machine state and compares field by field
// depends on rvec_pkg

module register_vm_execute_core_unit_checker
  import rvec_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_data_i,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  // machine state as the core should hold it
  logic [63:0] vm_regs [16];
  logic [63:0] vm_cmp;
  logic [16:0] vm_ret_stack [64];
  int          vm_ret_depth;
  logic [63:0] vm_data_stack [256];
  int          vm_data_depth;
  bit          vm_halted;
  logic [15:0] vm_prog_len;

  out_item_t   results_due [$];

  // truncating signed divide with the zero and minus-one cases
  function automatic logic [63:0] vm_divide(logic [63:0] a, logic [63:0] b);
    if (b == 64'd0) return a;
    if (b == '1) return 64'd0 - a;
    return $signed(a) / $signed(b);
  endfunction

  // executes one instruction on the machine state, returns its result
  function automatic out_item_t vm_execute(in_item_t it);
    out_item_t   res;
    logic [16:0] nxt;
    logic [63:0] dst;
    logic [63:0] src;
    logic [2:0]  err;
    bit          take;
    nxt  = {1'b0, it.instruction_address} + 17'd1;
    dst  = vm_regs[it.first_register];
    src  = vm_regs[it.second_register];
    err  = ERR_NONE;
    take = 0;
    res  = '0;
    if (vm_halted) begin
      res.next_address = {1'b0, it.instruction_address};
      res.done_res = 1'b1;
      return res;
    end
    case (it.operation)
      OP_MOVRI: dst = it.immediate_value;
      OP_MOVRR: dst = src;
      OP_ADDR:  dst = dst + src;
      OP_ADDI:  dst = dst + it.immediate_value;
      OP_SUBR:  dst = dst - src;
      OP_SUBI:  dst = dst - it.immediate_value;
      OP_MULR:  dst = dst * src;
      OP_MULI:  dst = dst * it.immediate_value;
      OP_DIVR:  dst = vm_divide(dst, src);
      OP_DIVI:  dst = vm_divide(dst, it.immediate_value);
      OP_CALL: begin
        if (vm_ret_depth >= 64) err = ERR_RET_FULL;
        else begin
          vm_ret_stack[vm_ret_depth] = nxt;
          vm_ret_depth++;
          nxt = {1'b0, it.jump_target};
        end
      end
      OP_RET: begin
        if (vm_ret_depth == 0) err = ERR_RET_EMPTY;
        else begin
          vm_ret_depth--;
          nxt = vm_ret_stack[vm_ret_depth];
        end
      end
      OP_PRINT: begin
        res.print_valid = 1'b1;
        res.print_value = dst;
      end
      OP_BLE: take = dst[63] || dst == 64'd0;
      OP_BGE: take = !dst[63];
      OP_CMP: vm_cmp = dst - src;
      OP_JMP: take = 1;
      OP_JE:  take = vm_cmp == 64'd0;
      OP_JNE: take = vm_cmp != 64'd0;
      OP_JL:  take = vm_cmp[63];
      OP_JLE: take = vm_cmp[63] || vm_cmp == 64'd0;
      OP_JG:  take = !vm_cmp[63] && vm_cmp != 64'd0;
      OP_JGE: take = !vm_cmp[63];
      OP_PUSH: begin
        if (vm_data_depth >= 256) err = ERR_DATA_FULL;
        else begin
          vm_data_stack[vm_data_depth] = dst;
          vm_data_depth++;
        end
      end
      OP_POP: begin
        if (vm_data_depth == 0) err = ERR_DATA_UNDR;
        else begin
          vm_data_depth--;
          dst = vm_data_stack[vm_data_depth];
        end
      end
      default: err = ERR_UNKNOWN;
    endcase
    if (take) nxt = {1'b0, it.jump_target};
    if (err != ERR_NONE) begin
      vm_halted = 1;
      res = '0;
      res.next_address = {1'b0, it.instruction_address};
      res.error_code = err;
      res.done_res = 1'b1;
      return res;
    end
    // only register-writing operations reach here with a changed dst
    vm_regs[it.first_register] = dst;
    res.next_address = nxt;
    res.done_res = nxt > {1'b0, vm_prog_len};
    return res;
  endfunction

  // one field compare with report
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  // channel monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    if (!rst_ni) begin
      foreach (vm_regs[i]) vm_regs[i] = '0;
      vm_cmp        = '0;
      vm_ret_depth  = 0;
      vm_data_depth = 0;
      vm_halted     = 0;
      vm_prog_len   = '0;
      results_due.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $realtime, out_data_i);
          fail_count_o++;
        end else begin
          exp_r = results_due.pop_front();
          check_field("next_address", 64'(exp_r.next_address),
                      64'(out_data_i.next_address));
          check_field("print_valid", 64'(exp_r.print_valid), 64'(out_data_i.print_valid));
          check_field("print_value", exp_r.print_value, out_data_i.print_value);
          check_field("error_code", 64'(exp_r.error_code), 64'(out_data_i.error_code));
          check_field("done_res", 64'(exp_r.done_res), 64'(out_data_i.done_res));
        end
      end
      if (in_valid_i && !in_stall_i)
        results_due.insert(results_due.size(), vm_execute(in_data_i));
      if (cfg_valid_i && cfg_ready_i) vm_prog_len = cfg_data_i;
      pending_o = results_due.size();
    end
  end

endmodule

FILE: bench/register_vm_execute_core_unit_test.sv
// top of the register vm execute core bench: clock, reset, stimulus and verdict
// depends on rvec_pkg, register_vm_execute_core_unit and its checker

module register_vm_execute_core_unit_test;
  import rvec_pkg::*;

  localparam logic [4:0] OpUnknownLo = 5'd25;
  localparam logic [4:0] OpUnknownHi = 5'd31;
  localparam int         DrainCycles = 80;
  localparam int         WatchLimit  = 4000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        in_valid_i = 0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;
  bit          no_idle = 0;
  int          ret_depth = 0;
  int          data_depth = 0;
  int          idle_cycles = 0;

  register_vm_execute_core_unit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  register_vm_execute_core_unit_checker checker_i (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 26);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // send one instruction item and keep track of stack depths
  task automatic issue(logic [4:0] op, logic [3:0] ra, logic [3:0] rb,
                       logic [63:0] imm, logic [15:0] target);
    in_item_t it;
    it.operation           = op;
    it.instruction_address = 16'($urandom_range(1, 65535));
    it.first_register      = ra;
    it.second_register     = rb;
    it.immediate_value     = imm;
    it.jump_target         = target;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_CALL: if (ret_depth < 64) ret_depth++;
      OP_RET:  if (ret_depth > 0) ret_depth--;
      OP_PUSH: if (data_depth < 256) data_depth++;
      OP_POP:  if (data_depth > 0) data_depth--;
      default: ;
    endcase
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 26);
    end
  endtask

  // wait until the core is idle, then write the program length
  task automatic set_program_length(logic [15:0] len);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return {$urandom_range(0, 1) ? 32'hffff_ffff : 32'd0, $urandom};
      default: return {1'b1, 63'($urandom_range(0, 3))};
    endcase
  endfunction

  // random well-formed instruction that cannot raise an error
  task automatic issue_random();
    logic [4:0] op;
    op = 5'($urandom_range(OP_MOVRI, OP_POP));
    if (op == OP_CALL && ret_depth >= 64) op = OP_RET;
    if (op == OP_RET && ret_depth == 0) op = OP_CALL;
    if (op == OP_PUSH && data_depth >= 256) op = OP_POP;
    if (op == OP_POP && data_depth == 0) op = OP_PUSH;
    issue(op, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), rand_wide(),
          16'($urandom_range(0, 65535)));
  endtask

  // stimulus
  initial begin
    logic [15:0] lengths [5];
    int          kind;
    lengths = '{16'd0, 16'd1, 16'd300, 16'hffff, 16'd0};
    lengths[2] = 16'($urandom_range(2, 65534));
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    set_program_length(16'hffff);
    issue(OP_MOVRI, 4'd0, 4'd0, 64'h7fff_ffff_ffff_ffff, 16'd1);
    issue(OP_MOVRI, 4'd15, 4'd0, 64'h8000_0000_0000_0000, 16'd1);
    issue(OP_MOVRR, 4'd3, 4'd0, 64'd0, 16'd1);
    issue(OP_ADDR, 4'd3, 4'd0, 64'd0, 16'd1);
    issue(OP_ADDI, 4'd4, 4'd0, 64'h7fff_ffff_ffff_ffff, 16'd1);
    issue(OP_SUBR, 4'd5, 4'd15, 64'd0, 16'd1);
    issue(OP_SUBI, 4'd6, 4'd0, 64'h8000_0000_0000_0000, 16'd1);
    issue(OP_MULR, 4'd0, 4'd0, 64'd0, 16'd1);
    issue(OP_MULI, 4'd4, 4'd0, 64'hffff_ffff_ffff_fffd, 16'd1);
    issue(OP_DIVR, 4'd15, 4'd9, 64'd0, 16'd1);   // divide by zero register
    issue(OP_DIVI, 4'd15, 4'd0, '1, 16'd1);      // most negative over minus one
    issue(OP_DIVI, 4'd4, 4'd0, 64'd7, 16'd1);
    issue(OP_CMP, 4'd0, 4'd15, 64'd0, 16'd1);
    issue(OP_JMP, 4'd0, 4'd0, 64'd0, 16'd0);     // jump to address zero
    issue(OP_JE, 4'd0, 4'd0, 64'd0, 16'hffff);
    issue(OP_JNE, 4'd0, 4'd0, 64'd0, 16'd2);
    issue(OP_JL, 4'd0, 4'd0, 64'd0, 16'd3);
    issue(OP_JLE, 4'd0, 4'd0, 64'd0, 16'd4);
    issue(OP_JG, 4'd0, 4'd0, 64'd0, 16'd5);
    issue(OP_JGE, 4'd0, 4'd0, 64'd0, 16'd6);
    issue(OP_BLE, 4'd15, 4'd0, 64'd0, 16'd7);
    issue(OP_BGE, 4'd9, 4'd0, 64'd0, 16'd8);
    issue(OP_CALL, 4'd0, 4'd0, 64'd0, 16'hffff);
    issue(OP_PUSH, 4'd15, 4'd0, 64'd0, 16'd0);
    issue(OP_POP, 4'd1, 4'd0, 64'd0, 16'd0);
    issue(OP_RET, 4'd0, 4'd0, 64'd0, 16'd0);
    issue(OP_PRINT, 4'd1, 4'd0, 64'd0, 16'd0);

    // random phases, each under its own program length
    for (int ph = 0; ph < 5; ph++) begin
      set_program_length(lengths[ph]);
      for (int n = 0; n < 320; n++) begin
        no_idle = (ph == 2 && n >= 40 && n < 260);
        issue_random();
      end
      no_idle = 0;
    end

    // finish with one error, then items on the stopped core
    kind = $urandom_range(0, 4);
    case (kind)
      0: issue(5'($urandom_range(OpUnknownLo, OpUnknownHi)), 4'($urandom_range(0, 15)),
               4'($urandom_range(0, 15)), rand_wide(), 16'($urandom_range(0, 65535)));
      1: begin
        while (ret_depth > 0) issue(OP_RET, 4'd0, 4'd0, 64'd0, 16'd0);
        issue(OP_RET, 4'd0, 4'd0, 64'd0, 16'd0);
      end
      2: begin
        while (data_depth > 0) issue(OP_POP, 4'($urandom_range(0, 15)), 4'd0, 64'd0, 16'd0);
        issue(OP_POP, 4'd2, 4'd0, 64'd0, 16'd0);
      end
      3: begin
        while (ret_depth < 64)
          issue(OP_CALL, 4'd0, 4'd0, 64'd0, 16'($urandom_range(1, 65535)));
        issue(OP_CALL, 4'd0, 4'd0, 64'd0, 16'd9);
      end
      default: begin
        while (data_depth < 256)
          issue(OP_PUSH, 4'($urandom_range(0, 15)), 4'd0, 64'd0, 16'd0);
        issue(OP_PUSH, 4'd3, 4'd0, 64'd0, 16'd0);
      end
    endcase
    repeat (6) issue(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                     4'($urandom_range(0, 15)), rand_wide(),
                     16'($urandom_range(0, 65535)));

    // drain and verdict
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
